/* hdl/cqd_pkg.sv */
// Package for the circular deque: sizes, operation and status codes,
// and the per-cell control word. No dependencies.
package cqd_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_POP_FRONT  = 2'd1,
    MODE_PUSH_REAR  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD     = 2'd0,
    CELL_FROM_LOW = 2'd1,
    CELL_FROM_HIGH = 2'd2,
    CELL_LOAD     = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctl_t;

endpackage : cqd_pkg

/* hdl/cqd_cell.sv */
// One storage cell of the deque chain: holds a word, takes a neighbour's
// word on a shift or loads a new word. Depends on cqd_pkg.
module cqd_cell (
  input  logic                          clk_i,
  input  cqd_pkg::cell_ctl_t            ctl_i,
  input  logic [cqd_pkg::WORD_W-1:0]    low_i,
  input  logic [cqd_pkg::WORD_W-1:0]    high_i,
  input  logic [cqd_pkg::WORD_W-1:0]    value_i,
  output logic [cqd_pkg::WORD_W-1:0]    data_o
);
  import cqd_pkg::*;

  logic [WORD_W-1:0] data_q;
  logic [WORD_W-1:0] data_d;

  always_comb begin
    case (ctl_i.op)
      CELL_FROM_LOW:  data_d = low_i;
      CELL_FROM_HIGH: data_d = high_i;
      CELL_LOAD:      data_d = value_i;
      default:        data_d = data_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule : cqd_cell

/* hdl/circular_deque.sv */
// Top level of the double-ended queue: a chain of cqd_cell storage cells,
// the occupancy count and the result register. Depends on cqd_pkg, cqd_cell.
//
// One operation is taken per clock cycle (busy_o stays low) and its result
// appears on data_o/status_o with valid_o high in the following cycle, for
// that single cycle only. The front word always sits in the first cell;
// a front push or pop shifts the whole chain by one cell in that cycle, a
// rear push loads the cell just past the last word, and a rear pop reads
// the last occupied cell. No clearing pass is needed after reset.
module circular_deque (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    mode_i,
  input  logic signed [cqd_pkg::WORD_W-1:0] value_i,
  output logic                          valid_o,
  output logic signed [cqd_pkg::WORD_W-1:0] data_o,
  output logic [1:0]                    status_o
);
  import cqd_pkg::*;

  logic [CNT_W-1:0]  count_q, count_d;
  logic              valid_q;
  logic [WORD_W-1:0] data_q, data_d;
  status_e           status_q, status_d;

  logic              accept;
  mode_e             mode;
  logic              is_full, is_empty;
  logic [WORD_W-1:0] rear_word;

  cell_ctl_t         ctl   [DEPTH];
  logic [WORD_W-1:0] cell_q [DEPTH];

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign mode     = mode_e'(mode_i);
  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WORD_W-1:0] low_w, high_w;

    if (k == 0) begin : g_first
      assign low_w = value_i;
    end else begin : g_mid
      assign low_w = cell_q[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign high_w = '0;
    end else begin : g_inner
      assign high_w = cell_q[k+1];
    end

    always_comb begin
      ctl[k].op = CELL_HOLD;
      if (accept) begin
        case (mode)
          MODE_PUSH_FRONT: if (!is_full) ctl[k].op = CELL_FROM_LOW;
          MODE_POP_FRONT:  if (!is_empty) ctl[k].op = CELL_FROM_HIGH;
          MODE_PUSH_REAR:
            if (!is_full && count_q == CNT_W'(k)) ctl[k].op = CELL_LOAD;
          default:         ctl[k].op = CELL_HOLD;
        endcase
      end
    end

    cqd_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[k]),
      .low_i   (low_w),
      .high_i  (high_w),
      .value_i (value_i),
      .data_o  (cell_q[k])
    );
  end

  // last occupied cell, selected by the count
  always_comb begin
    rear_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (count_q == CNT_W'(k + 1)) rear_word = rear_word | cell_q[k];
    end
  end

  always_comb begin
    count_d  = count_q;
    data_d   = '0;
    status_d = ST_DONE;
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
        if (is_full) status_d = ST_FULL;
        else count_d = count_q + CNT_W'(1);
      end
      MODE_POP_FRONT: begin
        if (is_empty) status_d = ST_EMPTY;
        else begin
          data_d  = cell_q[0];
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        if (is_empty) status_d = ST_EMPTY;
        else begin
          data_d  = rear_word;
          count_d = count_q - CNT_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      valid_q  <= 1'b0;
      data_q   <= '0;
      status_q <= ST_DONE;
    end else begin
      valid_q <= accept;
      if (accept) begin
        count_q  <= count_d;
        data_q   <= data_d;
        status_q <= status_d;
      end
    end
  end

  assign valid_o  = valid_q;
  assign data_o   = data_q;
  assign status_o = status_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_full && (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_REAR)
    |=> valid_o && status_o == ST_FULL && $stable(count_q))
    else $error("push on full not refused");

  a_empty_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_empty && (mode == MODE_POP_FRONT || mode == MODE_POP_REAR)
    |=> valid_o && status_o == ST_EMPTY && data_o == '0 && count_q == '0)
    else $error("pop on empty not refused");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q) && !valid_o)
    else $error("occupancy moved without an operation");

endmodule : circular_deque

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for circular_deque: a directed table with typed-in
// results, then biased random push/pop traffic checked against an in-bench
// deque predictor. Depends on cqd_pkg and the circular_deque RTL.
module testbench;
  import cqd_pkg::*;

  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int          STALL_MAX = 1000;
  localparam int          RAND_WORDS = 1250;

  typedef struct {
    mode_e       mode;
    logic [31:0] value;
    bit          given;
    logic [31:0] data;
    status_e     status;
  } row_t;

  typedef struct {
    logic [31:0] data;
    status_e     status;
  } outcome_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [1:0]         mode_i;
  logic signed [31:0] value_i;
  logic               valid_o;
  logic signed [31:0] data_o;
  logic [1:0]         status_o;

  // typed-in expectation travelling with the word on the ports
  bit          typed_given;
  logic [31:0] typed_data;
  status_e     typed_status;

  // predictor state
  logic [31:0]      deque_words [DEPTH];
  logic [IDX_W-1:0] front_pos;
  logic [IDX_W-1:0] rear_pos;
  int unsigned      word_count;

  outcome_t pending_results [$];
  row_t     directed_rows [$];
  int       fail_count;
  int       stall_cycles;
  bit       idle_on;

  circular_deque i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .mode_i   (mode_i),
    .value_i  (value_i),
    .valid_o  (valid_o),
    .data_o   (data_o),
    .status_o (status_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic outcome_t deque_apply(input mode_e m, input logic [31:0] v);
    outcome_t r;
    r.data   = '0;
    r.status = ST_DONE;
    case (m)
      MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
        if (word_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (m == MODE_PUSH_FRONT) begin
          front_pos = front_pos - 1'b1;
          deque_words[front_pos] = v;
          word_count++;
        end else begin
          deque_words[rear_pos] = v;
          rear_pos = rear_pos + 1'b1;
          word_count++;
        end
      end
      default: begin
        if (word_count == 0) begin
          r.status = ST_EMPTY;
        end else if (m == MODE_POP_FRONT) begin
          r.data = deque_words[front_pos];
          front_pos = front_pos + 1'b1;
          word_count--;
        end else begin
          rear_pos = rear_pos - 1'b1;
          r.data = deque_words[rear_pos];
          word_count--;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void add_row(input mode_e m, input logic [31:0] v, input bit g,
                                  input logic [31:0] d, input status_e s);
    row_t r;
    r.mode   = m;
    r.value  = v;
    r.given  = g;
    r.data   = d;
    r.status = s;
    directed_rows.push_back(r);
  endfunction

  // acceptance, prediction and result check in one process
  always @(posedge clk_i) begin
    outcome_t exp_r;
    outcome_t pred;
    bit       moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        moved = 1'b1;
        pred = deque_apply(mode_e'(mode_i), value_i);
        if (typed_given) begin
          pred.data   = typed_data;
          pred.status = typed_status;
        end
        pending_results.push_back(pred);
      end
      if (valid_o) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result with no word outstanding: data %h status %0d", data_o, status_o);
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (data_o !== exp_r.data) begin
            $error("data: expected %h, got %h", exp_r.data, data_o);
            fail_count++;
          end
          if (status_o !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_o);
            fail_count++;
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  task automatic drive_word(input mode_e m, input logic [31:0] v, input bit g,
                            input logic [31:0] d, input status_e s);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(99) < 30) gap = $urandom_range(3, 1);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    mode_i       <= m;
    value_i      <= v;
    typed_given  <= g;
    typed_data   <= d;
    typed_status <= s;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] pattern [4];
    int          push_bias;
    int          r;
    logic [31:0] v;
    mode_e       m;

    rst_ni       = 1'b0;
    start_i      = 1'b0;
    mode_i       = MODE_PUSH_FRONT;
    value_i      = '0;
    typed_given  = 1'b0;
    typed_data   = '0;
    typed_status = ST_DONE;
    front_pos    = '0;
    rear_pos     = '0;
    word_count   = 0;
    fail_count   = 0;
    stall_cycles = 0;
    idle_on      = 1'b1;
    pattern[0]   = 32'hFFFF_FFFF;
    pattern[1]   = 32'h0000_0000;
    pattern[2]   = 32'h5555_5555;
    pattern[3]   = 32'hAAAA_AAAA;
    foreach (deque_words[i]) deque_words[i] = '0;

    // empty pops, extremes at both ends, fill to full with wrap, push on full
    add_row(MODE_POP_FRONT,  32'hDEAD_BEEF, 1, 32'h0,         ST_EMPTY);
    add_row(MODE_POP_REAR,   32'h1234_5678, 1, 32'h0,         ST_EMPTY);
    add_row(MODE_PUSH_REAR,  32'h7FFF_FFFF, 1, 32'h0,         ST_DONE);
    add_row(MODE_PUSH_FRONT, 32'h8000_0000, 1, 32'h0,         ST_DONE);
    add_row(MODE_POP_REAR,   32'h0,         1, 32'h7FFF_FFFF, ST_DONE);
    add_row(MODE_POP_REAR,   32'h0,         1, 32'h8000_0000, ST_DONE);
    add_row(MODE_POP_FRONT,  32'h0,         1, 32'h0,         ST_EMPTY);
    for (int i = 0; i < DEPTH; i++) begin
      add_row(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_REAR, pattern[i % 4] ^ i, 1, 32'h0, ST_DONE);
    end
    add_row(MODE_PUSH_REAR,  32'h0000_0001, 1, 32'h0,         ST_FULL);
    add_row(MODE_PUSH_FRONT, 32'h0000_0002, 1, 32'h0,         ST_FULL);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      drive_word(directed_rows[i].mode, directed_rows[i].value, directed_rows[i].given,
                 directed_rows[i].data, directed_rows[i].status);
    end

    // push-heavy, balanced and pop-heavy bursts so full and empty both recur
    push_bias = 50;
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_bias = 15;
          1:       push_bias = 50;
          default: push_bias = 85;
        endcase
      end
      idle_on = !(n >= 500 && n < 800);
      r = $urandom_range(99);
      if (r < push_bias) m = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
      else               m = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_REAR;
      if ($urandom_range(7) == 0) v = pattern[$urandom_range(3)] ^ {1'b0, {31{r[0]}}};
      else                        v = $urandom;
      drive_word(m, v, 1'b0, 32'h0, ST_DONE);
    end

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule : testbench

/* filelist.f */
hdl/cqd_pkg.sv
hdl/cqd_cell.sv
hdl/circular_deque.sv
bench/testbench.sv
